FILE: hw/rtl/dfr_pkg.sv
// Shared types and constants of the delimited frame receiver.
// No dependencies; every other file of the block imports this package.
package dfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PKT     = 2'd2;

  // Register values after reset.
  localparam logic [31:0]       RST_DELIM_BYTES = 32'h0000_0A0D;
  localparam logic [2:0]        RST_DELIM_LEN   = 3'd2;
  localparam logic [BYTE_W-1:0] RST_MAX_PKT     = 8'd255;

  // Result kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Depth of the command queue between the front and back parts.
  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] frame_length;
    logic              last;
  } res_t;

endpackage

FILE: hw/rtl/delimited_frame_receiver_unit.sv
// Top level of the delimited frame receiver: configuration registers and the
// front part, command queue and back part. Uses dfr_pkg and all dfr_ modules.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid / in_stall | in_rx_byte
//   out     | output    | out_valid/out_stall | kind, payload_byte, byte_index,
//           |           |                     | frame_length, last
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// The front part takes one byte per cycle while the command queue has room.
// The back part takes the released bytes of a command (1 to MAX_DELIM_LEN)
// one at a time, and each delimiter match, emitting only into a free output slot.
// Results leave through a single output register; a stall holds it and
// backs up into the queue. Reset is synchronous and needs no clearing pass.
module delimited_frame_receiver_unit #(
  parameter int MAX_DELIM_LEN = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [7:0]                       out_byte_index,
  output logic [7:0]                       out_frame_length,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dfr_pkg::*;

  localparam int LEN_W = $clog2(MAX_DELIM_LEN + 1);
  localparam int CMD_W = 1 + LEN_W + MAX_DELIM_LEN * BYTE_W;

  logic [31:0]       delim_bytes_r;
  logic [2:0]        delim_len_r;
  logic [BYTE_W-1:0] max_pkt_r;
  logic              win_flush;

  logic                              cmd_push, cmd_match, cmd_full, cmd_empty, cmd_pop;
  logic [LEN_W-1:0]                  cmd_nrel;
  logic [MAX_DELIM_LEN*BYTE_W-1:0]   cmd_bytes;
  logic [CMD_W-1:0]                  cmd_head;
  res_t                              res;

  // A new delimiter length empties the window.
  assign win_flush = cfg_we && (cfg_index == REG_DELIM_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= RST_DELIM_BYTES;
      delim_len_r   <= RST_DELIM_LEN;
      max_pkt_r     <= RST_MAX_PKT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIM_BYTES: delim_bytes_r <= cfg_data;
        REG_DELIM_LEN:   delim_len_r   <= cfg_data[2:0];
        REG_MAX_PKT:     max_pkt_r     <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  dfr_front #(.MAX_DELIM_LEN(MAX_DELIM_LEN)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .delim_bytes (delim_bytes_r),
    .delim_len   (delim_len_r),
    .win_flush   (win_flush),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_match   (cmd_match),
    .cmd_nrel    (cmd_nrel),
    .cmd_bytes   (cmd_bytes)
  );

  dfr_cmd_fifo #(.WIDTH(CMD_W)) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data ({cmd_match, cmd_nrel, cmd_bytes}),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .full      (cmd_full),
    .empty     (cmd_empty)
  );

  dfr_back #(.MAX_DELIM_LEN(MAX_DELIM_LEN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .head_match (cmd_head[CMD_W-1]),
    .head_nrel  (cmd_head[CMD_W-2 -: LEN_W]),
    .head_bytes (cmd_head[MAX_DELIM_LEN*BYTE_W-1:0]),
    .cmd_pop    (cmd_pop),
    .max_pkt    (max_pkt_r),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign out_kind         = res.kind;
  assign out_payload_byte = res.payload_byte;
  assign out_byte_index   = res.byte_index;
  assign out_frame_length = res.frame_length;
  assign out_last         = res.last;

endmodule

FILE: hw/rtl/dfr_front.sv
// Front part: collects received bytes in the delimiter window, compares a full
// window with the delimiter and issues match or release commands. Uses dfr_pkg.
module dfr_front #(
  parameter int MAX_DELIM_LEN = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dfr_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic [31:0]                       delim_bytes,
  input  logic [2:0]                        delim_len,
  input  logic                              win_flush,
  input  logic                              cmd_full,
  output logic                              cmd_push,
  output logic                              cmd_match,
  output logic [$clog2(MAX_DELIM_LEN+1)-1:0] cmd_nrel,
  output logic [MAX_DELIM_LEN*dfr_pkg::BYTE_W-1:0] cmd_bytes
);
  import dfr_pkg::*;

  localparam int LEN_W = $clog2(MAX_DELIM_LEN + 1);
  localparam int IDX_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

  logic [BYTE_W-1:0] win_r   [MAX_DELIM_LEN];
  logic [BYTE_W-1:0] win_nxt [MAX_DELIM_LEN];
  logic [BYTE_W-1:0] wn      [MAX_DELIM_LEN];
  logic [BYTE_W-1:0] ws      [MAX_DELIM_LEN];
  logic [BYTE_W-1:0] dbyte   [MAX_DELIM_LEN];
  logic [LEN_W-1:0]  fill_r, fill_nxt, fill_inc, eff_len, nrel;
  logic              accept, full, match;

  // Delimiter bytes past the fourth compare as zero.
  for (genvar k = 0; k < MAX_DELIM_LEN; k++) begin : g_dbyte
    if (k < 4) begin : g_reg
      assign dbyte[k] = delim_bytes[8*k +: 8];
    end else begin : g_zero
      assign dbyte[k] = '0;
    end
  end

  always_comb begin
    if (delim_len == 3'd0) begin
      eff_len = LEN_W'(1);
    end else if (4'(delim_len) > 4'(MAX_DELIM_LEN)) begin
      eff_len = LEN_W'(MAX_DELIM_LEN);
    end else begin
      eff_len = LEN_W'(delim_len);
    end
  end

  assign in_stall = cmd_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [LEN_W:0] src;
    wn = win_r;
    wn[fill_r[IDX_W-1:0]] = in_rx_byte;
    fill_inc = fill_r + LEN_W'(1);
    full = (fill_inc == eff_len);

    match = 1'b1;
    for (int k = 0; k < MAX_DELIM_LEN; k++) begin
      if (LEN_W'(k) < eff_len && wn[k] != dbyte[k]) begin
        match = 1'b0;
      end
    end

    // The first byte always goes; release stops before the next byte that
    // could start a delimiter.
    nrel = eff_len;
    for (int k = MAX_DELIM_LEN - 1; k >= 1; k--) begin
      if (LEN_W'(k) < eff_len && wn[k] == dbyte[0]) begin
        nrel = LEN_W'(k);
      end
    end

    for (int j = 0; j < MAX_DELIM_LEN; j++) begin
      src = (LEN_W+1)'(j) + (LEN_W+1)'(nrel);
      if (src < (LEN_W+1)'(MAX_DELIM_LEN)) begin
        ws[j] = wn[src[IDX_W-1:0]];
      end else begin
        ws[j] = wn[j];
      end
    end

    for (int j = 0; j < MAX_DELIM_LEN; j++) begin
      cmd_bytes[8*j +: 8] = wn[j];
    end

    cmd_push  = accept && full;
    cmd_match = match;
    cmd_nrel  = nrel;

    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (win_flush) begin
      fill_nxt = '0;
    end else if (accept) begin
      if (!full) begin
        win_nxt  = wn;
        fill_nxt = fill_inc;
      end else if (match) begin
        fill_nxt = '0;
      end else begin
        win_nxt  = ws;
        fill_nxt = eff_len - nrel;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: hw/rtl/dfr_cmd_fifo.sv
// Short command queue between the front and back parts.
// Uses dfr_pkg for its depth.
module dfr_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);
  import dfr_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/dfr_back.sv
// Back part: carries out queued commands, keeps the payload count and the
// frame valid mark, and drives the registered result word. Uses dfr_pkg.
module dfr_back #(
  parameter int MAX_DELIM_LEN = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cmd_empty,
  input  logic                                      head_match,
  input  logic [$clog2(MAX_DELIM_LEN+1)-1:0]        head_nrel,
  input  logic [MAX_DELIM_LEN*dfr_pkg::BYTE_W-1:0]  head_bytes,
  output logic                                      cmd_pop,
  input  logic [dfr_pkg::BYTE_W-1:0]                max_pkt,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output dfr_pkg::res_t                             out_res
);
  import dfr_pkg::*;

  localparam int LEN_W = $clog2(MAX_DELIM_LEN + 1);
  localparam int IDX_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

  logic [BYTE_W-1:0] count_r, count_nxt;
  logic              fvalid_r, fvalid_nxt;
  logic [IDX_W-1:0]  sel_r, sel_nxt;
  logic              out_valid_r;
  res_t              out_res_r, res_nxt;
  logic              emit, slot_free, final_byte;
  logic [BYTE_W-1:0] cur_byte;

  assign slot_free  = !out_valid_r || !out_stall;
  assign cur_byte   = head_bytes[8*sel_r +: 8];
  assign final_byte = ((LEN_W'(sel_r) + LEN_W'(1)) == head_nrel);

  always_comb begin
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    res_nxt    = '0;
    count_nxt  = count_r;
    fvalid_nxt = fvalid_r;
    sel_nxt    = sel_r;
    if (!cmd_empty) begin
      if (head_match) begin
        if (!fvalid_r) begin
          // An overflowed frame ends quietly.
          cmd_pop    = 1'b1;
          count_nxt  = '0;
          fvalid_nxt = 1'b1;
        end else if (slot_free) begin
          emit                 = 1'b1;
          res_nxt.kind         = KIND_DONE;
          res_nxt.frame_length = count_r;
          res_nxt.last         = 1'b1;
          cmd_pop              = 1'b1;
          count_nxt            = '0;
        end
      end else if (!fvalid_r) begin
        cmd_pop = 1'b1;
        sel_nxt = '0;
      end else if (count_r < max_pkt) begin
        if (slot_free) begin
          emit                 = 1'b1;
          res_nxt.kind         = KIND_WRITE;
          res_nxt.payload_byte = cur_byte;
          res_nxt.byte_index   = count_r;
          // After the byte that reaches the limit nothing more is written.
          res_nxt.last = final_byte ||
                         (({1'b0, count_r} + 9'd1) == {1'b0, max_pkt});
          count_nxt = count_r + BYTE_W'(1);
          if (final_byte) begin
            cmd_pop = 1'b1;
            sel_nxt = '0;
          end else begin
            sel_nxt = sel_r + IDX_W'(1);
          end
        end
      end else begin
        // Overflow: the byte is dropped and the rest of the frame ignored.
        cmd_pop    = 1'b1;
        sel_nxt    = '0;
        count_nxt  = '0;
        fvalid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res_nxt;
    end
    if (!rst_n) begin
      count_r     <= '0;
      fvalid_r    <= 1'b1;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      fvalid_r <= fvalid_nxt;
      sel_r    <= sel_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: test/dfr_tb_pkg.sv
// Scoreboard for the delimited frame receiver testbench: a model of the receiver
// that predicts result words, and the checker for the words that come out.
// Depends on dfr_pkg.
package dfr_tb_pkg;

  import dfr_pkg::*;

  localparam int DELIM_MAX = 4;

  class frame_scoreboard;
    logic [31:0]       delim_bytes;
    logic [2:0]        delim_len;
    logic [BYTE_W-1:0] pkt_limit;
    logic [7:0]        window [DELIM_MAX];
    int unsigned       fill;
    logic [7:0]        count;
    bit                frame_ok;
    res_t              pending_results[$];
    res_t              held;
    bit                have_held;
    int                failures;

    function new();
      delim_bytes = RST_DELIM_BYTES;
      delim_len   = RST_DELIM_LEN;
      pkt_limit   = RST_MAX_PKT;
      foreach (window[k]) window[k] = '0;
      fill      = 0;
      count     = '0;
      frame_ok  = 1'b1;
      have_held = 1'b0;
      failures  = 0;
    endfunction

    function int unsigned delim_span();
      if (delim_len == 0) return 1;
      if (delim_len > DELIM_MAX) return DELIM_MAX;
      return 32'(delim_len);
    endfunction

    function logic [7:0] delim_at(int unsigned k);
      return delim_bytes[8*k +: 8];
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_DELIM_BYTES: delim_bytes = data;
        REG_DELIM_LEN: begin
          // A new length throws away whatever sits in the window.
          delim_len = data[2:0];
          fill      = 0;
        end
        REG_MAX_PKT: pkt_limit = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // The final word caused by one byte carries the last flag, so each new
    // word is held back until it is known whether another one follows.
    function void stage(res_t r);
      if (have_held) pending_results.push_back(held);
      held      = r;
      have_held = 1'b1;
    endfunction

    function void note_rx_byte(logic [7:0] rx);
      int unsigned span;
      int unsigned taken;
      bit          hit;
      res_t        r;
      span = delim_span();
      if (fill >= DELIM_MAX) fill = 0;
      window[fill] = rx;
      fill++;
      if (fill < span) return;
      hit = 1'b1;
      for (int unsigned k = 0; k < span; k++) begin
        if (window[k] != delim_at(k)) hit = 1'b0;
      end
      if (hit) begin
        fill = 0;
        if (frame_ok) begin
          r              = '0;
          r.kind         = KIND_DONE;
          r.frame_length = count;
          stage(r);
        end
        count    = '0;
        frame_ok = 1'b1;
      end else begin
        // Release the head byte, then every byte up to the next possible
        // start of the delimiter.
        taken = 0;
        do begin
          r              = '0;
          r.kind         = KIND_WRITE;
          r.payload_byte = window[taken];
          r.byte_index   = count;
          taken++;
          if (frame_ok) begin
            if (count < pkt_limit) begin
              stage(r);
              count++;
            end else begin
              count    = '0;
              frame_ok = 1'b0;
            end
          end
        end while (taken < span && window[taken] != delim_at(0));
        for (int unsigned k = 0; k + taken < fill; k++) window[k] = window[k + taken];
        fill -= taken;
      end
      if (have_held) begin
        held.last = 1'b1;
        pending_results.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    function void compare(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_result(logic kind, logic [7:0] payload_byte, logic [7:0] byte_index,
                               logic [7:0] frame_length, logic last_flag);
      res_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $error("result word with no prediction waiting: kind %0d", kind);
        return;
      end
      want = pending_results.pop_front();
      compare("kind", 8'(want.kind), 8'(kind));
      compare("payload_byte", want.payload_byte, payload_byte);
      compare("byte_index", want.byte_index, byte_index);
      compare("frame_length", want.frame_length, frame_length);
      compare("last", 8'(want.last), 8'(last_flag));
    endfunction
  endclass

endpackage

FILE: test/testbench.sv
// Top of the delimited frame receiver testbench: clock, reset, stimulus and
// random idling on both channels. Depends on dfr_pkg, dfr_tb_pkg and the
// delimited_frame_receiver_unit RTL.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import dfr_pkg::*;
  import dfr_tb_pkg::*;

  localparam int RANDOM_ITEMS  = 175;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  out_kind;
  logic [7:0]            out_payload_byte;
  logic [7:0]            out_byte_index;
  logic [7:0]            out_frame_length;
  logic                  out_last;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  frame_scoreboard sb;
  bit              in_idle_on  = 1'b0;
  bit              out_idle_on = 1'b0;
  int unsigned     bytes_sent  = 0;
  int unsigned     stall_left  = 0;
  int unsigned     quiet_cycles = 0;

  delimited_frame_receiver_unit #(.MAX_DELIM_LEN(DELIM_MAX)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_result(out_kind, out_payload_byte, out_byte_index, out_frame_length, out_last);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is
  // taken, with valid still high so the next word can follow at once.
  task automatic send_byte(input logic [7:0] rx);
    int unsigned gap;
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] payload_pick();
    case ($urandom_range(0, 5))
      0: return sb.delim_at(0);
      1: return sb.delim_at($urandom_range(0, sb.delim_span() - 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int unsigned plen);
    repeat (plen) send_byte(payload_pick());
    for (int unsigned k = 0; k < sb.delim_span(); k++) send_byte(sb.delim_at(k));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Bytes that cause no word may still be in flight when the last predicted
  // word arrives, so the block is given extra time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reconfigure();
    logic [31:0] delim;
    logic [7:0]  limit;
    delim = $urandom;
    // A delimiter of one repeated byte makes long release chains.
    if ($urandom_range(0, 3) == 0) delim = {4{delim[7:0]}};
    case ($urandom_range(0, 5))
      0: limit = 8'd0;
      1: limit = 8'd255;
      default: limit = 8'($urandom_range(1, 10));
    endcase
    drain();
    write_reg(REG_DELIM_BYTES, delim);
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_DELIM_LEN, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                            : $urandom_range(1, 4));
    end
    write_reg(REG_MAX_PKT, 32'(limit));
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin
    int unsigned random_end;
    int unsigned phase_end;
    int unsigned cut;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // CR LF delimiter after reset: a frame, an empty frame, false starts.
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h0D); send_byte(8'h0A);
    send_byte(8'h0D); send_byte(8'h0A);
    send_byte(8'h0D); send_byte(8'h41); send_byte(8'h0D); send_byte(8'h0D);
    send_byte(8'h0A);

    // Overflow drops the frame silently; the next one starts clean.
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_MAX_PKT, 32'd2);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h0D);
    send_byte(8'h0A); send_byte(8'h44); send_byte(8'h0D); send_byte(8'h0A);

    // Zero length acts as one byte; a zero size overflows on any payload.
    drain();
    write_reg(REG_DELIM_BYTES, 32'hFFFF_FFFF);
    write_reg(REG_DELIM_LEN, 32'd0);
    write_reg(REG_MAX_PKT, 32'd0);
    send_byte(8'h12); send_byte(8'hFF); send_byte(8'hFF);

    // Oversized length saturates; rewriting the length empties the window.
    drain();
    write_reg(REG_DELIM_BYTES, 32'h0000_0000);
    write_reg(REG_DELIM_LEN, 32'd7);
    write_reg(REG_MAX_PKT, 32'd255);
    send_byte(8'h00); send_byte(8'h00);
    drain();
    write_reg(REG_DELIM_LEN, 32'd4);
    send_byte(8'h5A); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00);

    random_end = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < random_end) begin
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      if (bytes_sent + 40 >= random_end) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      reconfigure();
      phase_end = bytes_sent + $urandom_range(25, 45);
      while (bytes_sent < phase_end && bytes_sent < random_end) begin
        if (bytes_sent + 40 >= random_end) begin
          in_idle_on  = 1'b0;
          out_idle_on = 1'b0;
        end
        case ($urandom_range(0, 7))
          0: send_byte(8'($urandom_range(0, 255)));
          1: begin
            // A delimiter cut short by a random byte.
            cut = $urandom_range(1, sb.delim_span());
            for (int unsigned k = 0; k + 1 < cut; k++) send_byte(sb.delim_at(k));
            send_byte(8'($urandom_range(0, 255)));
          end
          default: send_frame($urandom_range(0, (sb.pkt_limit < 8) ? sb.pkt_limit + 2 : 10));
        endcase
      end
    end

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    drain();
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
